/* rtl/lfpd_pkg.sv */
// Shared types and constants for the PID line-follower drive block.
// No dependencies; imported by line_follow_pid_drive.
package lfpd_pkg;

  localparam int POS_W    = 13;
  localparam int TIME_W   = 32;
  localparam int GAIN_W   = 16;
  localparam int SPEED_W  = 8;
  localparam int HOLD_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 24;

  localparam logic [POS_W-1:0] CENTRE_POS = 13'd3500;
  localparam logic [POS_W-1:0] MAX_POS    = 13'd7000;

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_HOLD  = 3'd5;

  localparam logic [GAIN_W-1:0]  GAIN_P_RST     = 16'd205;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST     = 16'd0;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST     = 16'd2048;
  localparam logic [SPEED_W-1:0] BASE_SPEED_RST = 8'd50;
  localparam logic [SPEED_W-1:0] TOP_SPEED_RST  = 8'd255;
  localparam logic [HOLD_W-1:0]  STOP_HOLD_RST  = 16'd1000;

  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] time_ms;
    logic              stop_button;
    logic              stop_marker;
    logic [POS_W-1:0]  position;
  } sample_t;

  typedef struct packed {
    logic               finished;
    logic [SPEED_W-1:0] right_drive;
    logic [SPEED_W-1:0] left_drive;
  } drive_t;

endpackage

/* rtl/line_follow_pid_drive.sv */
// PID line-follower differential drive: top level, single compute stage.
// Depends on lfpd_pkg for field widths, register indexes and reset values.
//
// One request is taken per clock unless the output stalls. A request lands
// in an input register and its drive result is then loaded into the output
// register; the block sustains one request per cycle while out_tready holds
// up. That rate is set by the integral and previous-error registers, which
// close their feedback loop through the single compute stage on every
// request. A start request (kind 0) clears the stop timing and returns
// zero drive; a sample that ends the run, and every sample after it, returns
// zero drive with finished set.
module line_follow_pid_drive #(
  parameter int GAIN_FRAC_BITS = 12,
  parameter int INTEGRAL_BITS  = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [12:0] position, [13] stop_marker, [14] stop_button, [46:15] time_ms, [47] unused
  input  logic [lfpd_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] kind
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] left_drive, [15:8] right_drive, [16] finished, [23:17] zero
  output logic [lfpd_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lfpd_pkg::*;

  localparam int IB    = INTEGRAL_BITS;
  localparam int FB    = GAIN_FRAC_BITS;
  localparam int P_W   = 30;
  localparam int I_W   = IB + 17;
  localparam int D_W   = 31;
  localparam int SUM_W = IB + 19;

  logic [GAIN_W-1:0]  gain_p_r, gain_i_r, gain_d_r;
  logic [SPEED_W-1:0] base_speed_r, top_speed_r;
  logic [HOLD_W-1:0]  stop_hold_r;

  logic    s1_valid_r;
  sample_t s1_r;
  logic    out_valid_r;
  drive_t  out_r;

  logic signed [IB-1:0]    integral_r, integral_nxt;
  logic signed [POS_W-1:0] prev_err_r;
  logic                    hold_armed_r, hold_armed_nxt;
  logic [TIME_W-1:0]       hold_start_r, hold_start_nxt;
  logic                    run_done_r, run_done_nxt;

  logic    out_adv, s1_fire, in_fire;
  drive_t  result_nxt;

  logic [POS_W-1:0]        pos_sat;
  logic signed [POS_W-1:0] err_now;
  logic signed [IB:0]      integ_ext;
  logic signed [POS_W:0]   slope;
  logic signed [P_W-1:0]   prod_p;
  logic signed [I_W-1:0]   prod_i;
  logic signed [D_W-1:0]   prod_d;
  logic signed [SUM_W-1:0] pid_sum, sum_adj, corr;
  logic signed [SUM_W:0]   lft_raw, rgt_raw;
  logic [SPEED_W-1:0]      lft_clamp, rgt_clamp;
  logic [TIME_W-1:0]       held_ms;

  assign cfg_ready  = 1'b1;
  assign out_adv    = !out_valid_r || out_tready;
  assign s1_fire    = s1_valid_r && out_adv;
  assign in_tready  = !s1_valid_r || out_adv;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - 17){1'b0}}, out_r};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r     <= GAIN_P_RST;
      gain_i_r     <= GAIN_I_RST;
      gain_d_r     <= GAIN_D_RST;
      base_speed_r <= BASE_SPEED_RST;
      top_speed_r  <= TOP_SPEED_RST;
      stop_hold_r  <= STOP_HOLD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAIN_P:     gain_p_r     <= cfg_data;
        REG_GAIN_I:     gain_i_r     <= cfg_data;
        REG_GAIN_D:     gain_d_r     <= cfg_data;
        REG_BASE_SPEED: base_speed_r <= cfg_data[SPEED_W-1:0];
        REG_TOP_SPEED:  top_speed_r  <= cfg_data[SPEED_W-1:0];
        REG_STOP_HOLD:  stop_hold_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // PID datapath
  always_comb begin
    pos_sat = (s1_r.position > MAX_POS) ? MAX_POS : s1_r.position;
    err_now = $signed(CENTRE_POS - pos_sat);

    integ_ext = $signed({integral_r[IB-1], integral_r})
              + $signed({{(IB + 1 - POS_W){err_now[POS_W-1]}}, err_now});
    if (integ_ext[IB] != integ_ext[IB-1]) begin
      integral_nxt = integ_ext[IB] ? $signed({1'b1, {(IB-1){1'b0}}})
                                   : $signed({1'b0, {(IB-1){1'b1}}});
    end else begin
      integral_nxt = integ_ext[IB-1:0];
    end

    slope = $signed({err_now[POS_W-1], err_now}) - $signed({prev_err_r[POS_W-1], prev_err_r});

    prod_p = $signed({{(P_W - GAIN_W){1'b0}}, gain_p_r})
           * $signed({{(P_W - POS_W){err_now[POS_W-1]}}, err_now});
    prod_i = $signed({{(I_W - GAIN_W){1'b0}}, gain_i_r})
           * $signed({{(I_W - IB){integral_nxt[IB-1]}}, integral_nxt});
    prod_d = $signed({{(D_W - GAIN_W){1'b0}}, gain_d_r})
           * $signed({{(D_W - POS_W - 1){slope[POS_W]}}, slope});

    pid_sum = $signed({{(SUM_W - P_W){prod_p[P_W-1]}}, prod_p})
            + $signed({{(SUM_W - I_W){prod_i[I_W-1]}}, prod_i})
            + $signed({{(SUM_W - D_W){prod_d[D_W-1]}}, prod_d});
    // round toward zero before the arithmetic shift
    sum_adj = pid_sum + (pid_sum[SUM_W-1] ? $signed({{(SUM_W - FB){1'b0}}, {FB{1'b1}}})
                                          : $signed({SUM_W{1'b0}}));
    corr = sum_adj >>> FB;

    lft_raw = $signed({{(SUM_W + 1 - SPEED_W){1'b0}}, base_speed_r})
            + $signed({corr[SUM_W-1], corr});
    rgt_raw = $signed({{(SUM_W + 1 - SPEED_W){1'b0}}, base_speed_r})
            - $signed({corr[SUM_W-1], corr});

    if (lft_raw[SUM_W]) begin
      lft_clamp = '0;
    end else if (lft_raw[SUM_W-1:0] > {{(SUM_W - SPEED_W){1'b0}}, top_speed_r}) begin
      lft_clamp = top_speed_r;
    end else begin
      lft_clamp = lft_raw[SPEED_W-1:0];
    end
    if (rgt_raw[SUM_W]) begin
      rgt_clamp = '0;
    end else if (rgt_raw[SUM_W-1:0] > {{(SUM_W - SPEED_W){1'b0}}, top_speed_r}) begin
      rgt_clamp = top_speed_r;
    end else begin
      rgt_clamp = rgt_raw[SPEED_W-1:0];
    end
  end

  // stop timing and result select
  always_comb begin
    held_ms        = s1_r.time_ms - hold_start_r;
    hold_armed_nxt = hold_armed_r;
    hold_start_nxt = hold_start_r;
    run_done_nxt   = run_done_r;
    result_nxt     = '0;
    if (s1_r.kind == KIND_START) begin
      hold_armed_nxt = 1'b0;
      hold_start_nxt = '0;
      run_done_nxt   = 1'b0;
    end else if (run_done_r) begin
      result_nxt.finished = 1'b1;
    end else begin
      if (s1_r.stop_marker) begin
        if (!hold_armed_r) begin
          hold_armed_nxt = 1'b1;
          hold_start_nxt = s1_r.time_ms;
        end else if (held_ms > {{(TIME_W - HOLD_W){1'b0}}, stop_hold_r}) begin
          run_done_nxt = 1'b1;
        end
      end else begin
        hold_armed_nxt = 1'b0;
        hold_start_nxt = '0;
      end
      if (s1_r.stop_button) begin
        run_done_nxt = 1'b1;
      end
      if (run_done_nxt) begin
        result_nxt.finished = 1'b1;
      end else begin
        result_nxt.left_drive  = lft_clamp;
        result_nxt.right_drive = rgt_clamp;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= {in_tuser, in_tdata[46:15], in_tdata[14], in_tdata[13], in_tdata[12:0]};
    end
  end

  // loop state, advanced once per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r   <= '0;
      prev_err_r   <= '0;
      hold_armed_r <= 1'b0;
      hold_start_r <= '0;
      run_done_r   <= 1'b0;
    end else if (s1_fire) begin
      hold_armed_r <= hold_armed_nxt;
      hold_start_r <= hold_start_nxt;
      run_done_r   <= run_done_nxt;
      if (s1_r.kind == KIND_SAMPLE && !run_done_r) begin
        integral_r <= integral_nxt;
        prev_err_r <= err_now;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_r <= result_nxt;
    end
  end

`ifndef SYNTH
  a_finished_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.finished |-> out_r.left_drive == '0 && out_r.right_drive == '0)
    else $error("finished result carries nonzero drive");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_r.kind == KIND_START |=> !run_done_r && !hold_armed_r && hold_start_r == '0)
    else $error("start request did not clear stop timing");

  a_done_from_sample: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(run_done_r) |-> $past(s1_fire) && $past(s1_r.kind) == KIND_SAMPLE)
    else $error("run ended without a sample");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |-> !in_tready && !s1_fire)
    else $error("request taken while both stages are full and stalled");

  a_state_frozen_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_r.kind == KIND_SAMPLE && run_done_r |=>
      $stable(integral_r) && $stable(prev_err_r) && run_done_r)
    else $error("loop state moved after the run ended");
`endif

endmodule
